// ===== sv/ili_pkg.sv =====
`timescale 1ns / 1ps
package ili_pkg;

    localparam int FUNC_W      = 3;
    localparam int POS_W       = 8;
    localparam int VALUE_IN_W  = 16;
    localparam int VALUE_OUT_W = 16;
    localparam int STATUS_W    = 2;
    localparam int LENGTH_W    = 7;

    localparam int CAPACITY_DEFAULT    = 64;
    localparam int VALUE_WIDTH_DEFAULT = 16;

    // cells per registered OR group on the read path
    localparam int GROUP_SIZE = 8;

    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_HEAD   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TAIL   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_AT     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_INSERT,
        SHIFT_DELETE
    } shift_op_t;

    // what travels down the result pipeline alongside the read data
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] length;
    } res_meta_t;

endpackage

// ===== sv/ili_cell.sv =====
`timescale 1ns / 1ps
module ili_cell #(
    parameter int IDX         = 0,
    parameter int PW          = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  ili_pkg::shift_op_t     op,
    input  logic [PW-1:0]          pos,
    input  logic                   rd_en,
    input  logic [VALUE_WIDTH-1:0] ins_value,
    input  logic [VALUE_WIDTH-1:0] left,
    input  logic [VALUE_WIDTH-1:0] right,
    output logic [VALUE_WIDTH-1:0] data,
    output logic [VALUE_WIDTH-1:0] rd_tap
);

    localparam logic [PW-1:0] IDX_P = PW'(IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            ili_pkg::SHIFT_HOLD:
            begin
                data_next = data_reg;
            end
            ili_pkg::SHIFT_INSERT:
            begin
                // cells past the slot take from the left, the slot takes the new value
                if (IDX_P > pos)
                begin
                    data_next = left;
                end
                else if (IDX_P == pos)
                begin
                    data_next = ins_value;
                end
            end
            ili_pkg::SHIFT_DELETE:
            begin
                if (IDX_P >= pos)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign rd_tap = (rd_en && (IDX_P == pos)) ? data_reg : '0;

endmodule

// ===== sv/ili_or_group.sv =====
`timescale 1ns / 1ps
module ili_or_group #(
    parameter int N = 8,
    parameter int W = 16
) (
    input  logic                clk,
    input  logic [N-1:0][W-1:0] taps,
    output logic [W-1:0]        group_or
);

    logic [W-1:0] or_reg;
    logic [W-1:0] or_next;

    always_comb
    begin
        or_next = '0;
        for (int i = 0; i < N; i++)
        begin
            or_next = or_next | taps[i];
        end
    end

    always_ff @(posedge clk)
    begin
        or_reg <= or_next;
    end

    assign group_or = or_reg;

endmodule

// ===== sv/indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps
// A result strobes on done once its command has passed the stage-1 registers and then the output registers.
// Throughput: one command per cycle; busy stays low and the cell row shifts as each command is taken.
// Reads go through a registered OR of per-group taps, then a final OR into the result register.
// Reset (rst_n, async, active low) clears the length, the stage-1 metadata and done;
// stored values are not cleared. The receiver cannot stall: done lasts one cycle.
module indexed_list_insert_delete #(
    parameter int CAPACITY    = ili_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = ili_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ili_pkg::FUNC_W-1:0]      func,
    input  logic [ili_pkg::POS_W-1:0]       position,
    input  logic [ili_pkg::VALUE_IN_W-1:0]  value_in,
    output logic                            done,
    output logic [ili_pkg::VALUE_OUT_W-1:0] value_out,
    output logic [ili_pkg::STATUS_W-1:0]    status,
    output logic [ili_pkg::LENGTH_W-1:0]    length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ili_pkg::POS_W) ? CW : ili_pkg::POS_W;
    localparam int GS = ili_pkg::GROUP_SIZE;
    localparam int NG = (CAPACITY + GS - 1) / GS;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] cell_pos;
    logic          full;
    logic          rd_ok;
    logic          ins_ok;
    logic          del_ok;
    logic [ili_pkg::STATUS_W-1:0] st_now;
    ili_pkg::shift_op_t shift_op;

    logic [VALUE_WIDTH-1:0] ins_value;
    logic [CAPACITY-1:0][VALUE_WIDTH-1:0] cell_data;
    logic [NG*GS-1:0][VALUE_WIDTH-1:0]    taps;
    logic [NG-1:0][VALUE_WIDTH-1:0]       group_or;
    logic [VALUE_WIDTH-1:0]               read_or;

    ili_pkg::res_meta_t meta_s1_reg;
    ili_pkg::res_meta_t meta_s1_next;

    logic                            done_reg;
    logic [ili_pkg::VALUE_OUT_W-1:0] value_out_reg;
    logic [ili_pkg::STATUS_W-1:0]    status_reg;
    logic [ili_pkg::LENGTH_W-1:0]    length_reg;

    assign busy      = 1'b0;
    assign pos_ext   = PW'(position);
    assign cnt_ext   = PW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign ins_value = VALUE_WIDTH'(value_in);

    always_comb
    begin
        rd_ok    = 1'b0;
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        cell_pos = pos_ext;
        st_now   = ili_pkg::ST_DONE;
        unique case (func)
            ili_pkg::FUNC_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    rd_ok = 1'b1;
                end
                else
                begin
                    st_now = ili_pkg::ST_INVALID;
                end
            end
            ili_pkg::FUNC_HEAD:
            begin
                cell_pos = '0;
                if (full)
                begin
                    st_now = ili_pkg::ST_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            ili_pkg::FUNC_TAIL:
            begin
                cell_pos = cnt_ext;
                if (full)
                begin
                    st_now = ili_pkg::ST_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            ili_pkg::FUNC_AT:
            begin
                // out-of-range index wins over a full store
                if (pos_ext > cnt_ext)
                begin
                    st_now = ili_pkg::ST_INVALID;
                end
                else if (full)
                begin
                    st_now = ili_pkg::ST_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            ili_pkg::FUNC_DELETE:
            begin
                if (pos_ext < cnt_ext)
                begin
                    del_ok = 1'b1;
                end
                else
                begin
                    st_now = ili_pkg::ST_INVALID;
                end
            end
            default:
            begin
                st_now = ili_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        shift_op   = ili_pkg::SHIFT_HOLD;
        count_next = count_reg;
        if (start && ins_ok)
        begin
            shift_op   = ili_pkg::SHIFT_INSERT;
            count_next = count_reg + 1'b1;
        end
        else if (start && del_ok)
        begin
            shift_op   = ili_pkg::SHIFT_DELETE;
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        meta_s1_next.valid  = start;
        meta_s1_next.status = st_now;
        meta_s1_next.length = ili_pkg::LENGTH_W'(count_next);
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_in;
            logic [VALUE_WIDTH-1:0] right_in;

            if (i == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[i+1];
            end

            ili_cell #(
                .IDX         (i),
                .PW          (PW),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .op        (shift_op),
                .pos       (cell_pos),
                .rd_en     (start && rd_ok),
                .ins_value (ins_value),
                .left      (left_in),
                .right     (right_in),
                .data      (cell_data[i]),
                .rd_tap    (taps[i])
            );
        end

        for (genvar i = CAPACITY; i < NG * GS; i++)
        begin : g_pad
            assign taps[i] = '0;
        end

        for (genvar g = 0; g < NG; g++)
        begin : g_group
            ili_or_group #(
                .N (GS),
                .W (VALUE_WIDTH)
            ) u_group (
                .clk      (clk),
                .taps     (taps[g*GS +: GS]),
                .group_or (group_or[g])
            );
        end
    endgenerate

    always_comb
    begin
        read_or = '0;
        for (int g = 0; g < NG; g++)
        begin
            read_or = read_or | group_or[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            meta_s1_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            meta_s1_reg <= meta_s1_next;
            done_reg    <= meta_s1_reg.valid;
        end
    end

    // taps are zero unless a valid read hit, so no extra gating here
    always_ff @(posedge clk)
    begin
        value_out_reg <= ili_pkg::VALUE_OUT_W'(read_or);
        status_reg    <= meta_s1_reg.status;
        length_reg    <= meta_s1_reg.length;
    end

    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign length    = length_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("length exceeds capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && ins_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the length");

    a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && del_ok) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("delete did not shrink the length");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("command beat without a result");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ili_pkg::ST_DONE)) |-> (value_out == '0))
        else $error("nonzero value on a failed command");
`endif

endmodule

// ===== dv/ili_checker.sv =====
`timescale 1ns / 1ps
module ili_checker
    import ili_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [FUNC_W-1:0]      func,
    input  logic [POS_W-1:0]       position,
    input  logic [VALUE_IN_W-1:0]  value_in,
    input  logic                   done,
    input  logic [VALUE_OUT_W-1:0] value_out,
    input  logic [STATUS_W-1:0]    status,
    input  logic [LENGTH_W-1:0]    length,
    output int                     fail_count,
    output int                     pending,
    output logic [LENGTH_W-1:0]    fill
);

    typedef struct packed {
        logic [VALUE_OUT_W-1:0] value;
        logic [STATUS_W-1:0]    status;
        logic [LENGTH_W-1:0]    length;
    } outcome_t;

    logic [VALUE_WIDTH-1:0] cells [CAPACITY];
    int unsigned            seq_len;
    outcome_t               outcome_q[$];
    int                     errors;

    function automatic void open_slot(int unsigned at, logic [VALUE_IN_W-1:0] v);
        for (int i = seq_len; i > at; i--)
            cells[i] = cells[i-1];
        cells[at] = VALUE_WIDTH'(v);
        seq_len++;
    endfunction

    function automatic outcome_t apply_command(logic [FUNC_W-1:0] f,
                                               logic [POS_W-1:0] p,
                                               logic [VALUE_IN_W-1:0] v);
        outcome_t    o;
        int unsigned pos;
        o = '0;
        pos = p;
        o.status = ST_DONE;
        case (f)
            FUNC_READ:
                if (pos < seq_len)
                    o.value = cells[pos];
                else
                    o.status = ST_INVALID;
            FUNC_HEAD:
                if (seq_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                    open_slot(0, v);
            FUNC_TAIL:
                if (seq_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                    open_slot(seq_len, v);
            FUNC_AT:
                // out-of-range position wins over full
                if (pos > seq_len)
                    o.status = ST_INVALID;
                else if (seq_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                    open_slot(pos, v);
            FUNC_DELETE:
                if (pos < seq_len)
                begin
                    for (int i = pos; i + 1 < seq_len; i++)
                        cells[i] = cells[i+1];
                    seq_len--;
                end
                else
                    o.status = ST_INVALID;
            default:
                o.status = ST_INVALID;
        endcase
        o.length = seq_len[LENGTH_W-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        outcome_t want;
        if (!rst_n)
        begin
            seq_len = 0;
            errors = 0;
            outcome_q.delete();
            fail_count <= 0;
            pending <= 0;
            fill <= '0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result beat: value_out %h status %0d length %0d",
                                 $realtime, value_out, status, length);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (value_out !== want.value || status !== want.status
                        || length !== want.length)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: value_out %h/%h status %0d/%0d length %0d/%0d (exp/got)",
                                     $realtime, want.value, value_out, want.status, status,
                                     want.length, length);
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_command(func, position, value_in));
            fail_count <= errors;
            pending <= outcome_q.size();
            fill <= seq_len[LENGTH_W-1:0];
        end
    end

endmodule

// ===== dv/indexed_list_insert_delete_test.sv =====
`timescale 1ns / 1ps
module indexed_list_insert_delete_test;
    import ili_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int VALUE_WIDTH  = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int STALL_LIMIT  = 500;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [FUNC_W-1:0]      func;
    logic [POS_W-1:0]       position;
    logic [VALUE_IN_W-1:0]  value_in;
    logic                   done;
    logic [VALUE_OUT_W-1:0] value_out;
    logic [STATUS_W-1:0]    status;
    logic [LENGTH_W-1:0]    length;

    int                     fail_count;
    int                     pending;
    logic [LENGTH_W-1:0]    fill;
    int                     stuck;
    logic                   quiet;

    indexed_list_insert_delete #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .position  (position),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .status    (status),
        .length    (length)
    );

    ili_checker #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .position   (position),
        .value_in   (value_in),
        .done       (done),
        .value_out  (value_out),
        .status     (status),
        .length     (length),
        .fail_count (fail_count),
        .pending    (pending),
        .fill       (fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // no beat in either direction for too long means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stuck <= 0;
        else if (stuck >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stuck <= stuck + 1;
    end

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                            input logic [VALUE_IN_W-1:0] v);
        while (!quiet && $urandom_range(99) < 13)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        position <= p;
        value_in <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_empty();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : stim
        logic                  grow;
        int                    full_hits;
        int                    roll;
        int                    ins_pct;
        logic [FUNC_W-1:0]     f;
        logic [POS_W-1:0]      p;
        logic [VALUE_IN_W-1:0] v;

        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_READ;
        position = '0;
        value_in = '0;
        quiet = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store: positions out of range, then unknown function codes
        send_cmd(FUNC_READ, 8'd0, 16'h0000);
        send_cmd(FUNC_DELETE, 8'd0, 16'hFFFF);
        send_cmd(FUNC_AT, 8'd1, 16'hFFFF);
        send_cmd(FUNC_READ, 8'd255, 16'h0000);
        send_cmd(3'd5, 8'd255, 16'hFFFF);
        send_cmd(3'd6, 8'd0, 16'h0000);
        send_cmd(3'd7, 8'd170, 16'hA5A5);
        // build a short list through every insert flavor, then read and delete from it
        send_cmd(FUNC_AT, 8'd0, 16'h0000);
        send_cmd(FUNC_HEAD, 8'd0, 16'hFFFF);
        send_cmd(FUNC_TAIL, 8'd0, 16'h1234);
        send_cmd(FUNC_AT, 8'd3, 16'h8000);
        send_cmd(FUNC_AT, 8'd1, 16'h5A5A);
        send_cmd(FUNC_AT, 8'd9, 16'h7FFF);
        send_cmd(FUNC_READ, 8'd0, 16'h0000);
        send_cmd(FUNC_READ, 8'd4, 16'h0000);
        send_cmd(FUNC_READ, 8'd5, 16'h0000);
        send_cmd(FUNC_DELETE, 8'd4, 16'h0000);
        send_cmd(FUNC_DELETE, 8'd0, 16'h0000);
        send_cmd(FUNC_DELETE, 8'd255, 16'h0000);
        send_cmd(FUNC_READ, 8'd1, 16'h0000);
        send_cmd(FUNC_READ, 8'd2, 16'h0000);
        wait_empty();

        // random part swings between filling to capacity and draining to empty
        grow = 1'b1;
        full_hits = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 500 && n < 700);
            if (n == 900)
                wait_empty();
            if (fill >= CAPACITY)
                full_hits++;
            if (full_hits >= 8)
            begin
                grow = 1'b0;
                full_hits = 0;
            end
            if (fill == 0)
                grow = 1'b1;

            ins_pct = grow ? 65 : 25;
            roll = $urandom_range(99);
            if (roll < ins_pct)
            begin
                case ($urandom_range(2))
                    0: f = FUNC_HEAD;
                    1: f = FUNC_TAIL;
                    default: f = FUNC_AT;
                endcase
            end
            else if (roll < ins_pct + 15)
                f = FUNC_READ;
            else if (roll < 96)
                f = FUNC_DELETE;
            else
                f = FUNC_W'($urandom_range(5, 7));

            roll = $urandom_range(99);
            if (roll < 80)
                p = POS_W'($urandom_range(fill, 0));
            else if (roll < 90)
                p = POS_W'(fill);
            else
                p = POS_W'($urandom_range(255));

            roll = $urandom_range(99);
            if (roll < 5)
                v = '0;
            else if (roll < 10)
                v = '1;
            else
                v = VALUE_IN_W'($urandom_range(16'hFFFF));

            send_cmd(f, p, v);
        end

        wait_empty();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ili_pkg.sv
sv/ili_cell.sv
sv/ili_or_group.sv
sv/indexed_list_insert_delete.sv
dv/ili_checker.sv
dv/indexed_list_insert_delete_test.sv
